// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/dmd_pkg.sv =====
`default_nettype none

package dmd_pkg;

  // day count width
  localparam int DAYS_BITS = 22;
  // wide compare width for day counts against day of year
  localparam int WIDE_W = 33;

  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int DOY_W = 9;
  localparam int M100_W = 7;

  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0] CENTURY = YEAR_W'(100);
  localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
  localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // sequencer steps
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHK,
    S_DOY,
    S_YEAR,
    S_MON,
    S_OUT
  } step_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_START,
    C_GE100,
    C_BAD,
    C_MI_LT,
    C_FIT,
    C_FIRST,
    C_MON_MORE
  } cond_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD_SUB,
    OP_MOD_DONE,
    OP_BAD,
    OP_DOY_INIT,
    OP_DOY_ADD,
    OP_DOY_DAY,
    OP_FIT,
    OP_UFL,
    OP_YEAR_BACK,
    OP_MON_SUB,
    OP_MON_DONE
  } op_t;

  // one control word: two prioritized branches and a fall-through
  typedef struct packed {
    cond_t cond_a;
    op_t   op_a;
    step_t tgt_a;
    cond_t cond_b;
    op_t   op_b;
    step_t tgt_b;
    op_t   op_c;
    step_t tgt_c;
  } ucode_t;

  // control store
  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    w = '{C_NEVER, OP_NONE, S_IDLE, C_NEVER, OP_NONE, S_IDLE, OP_NONE, S_IDLE};
    unique case (s)
      S_IDLE: w = '{C_START, OP_LOAD, S_MOD, C_NEVER, OP_NONE, S_IDLE,
                    OP_NONE, S_IDLE};
      S_MOD:  w = '{C_GE100, OP_MOD_SUB, S_MOD, C_NEVER, OP_NONE, S_IDLE,
                    OP_MOD_DONE, S_CHK};
      S_CHK:  w = '{C_BAD, OP_BAD, S_OUT, C_NEVER, OP_NONE, S_IDLE,
                    OP_DOY_INIT, S_DOY};
      S_DOY:  w = '{C_MI_LT, OP_DOY_ADD, S_DOY, C_NEVER, OP_NONE, S_IDLE,
                    OP_DOY_DAY, S_YEAR};
      S_YEAR: w = '{C_FIT, OP_FIT, S_MON, C_FIRST, OP_UFL, S_OUT,
                    OP_YEAR_BACK, S_YEAR};
      S_MON:  w = '{C_MON_MORE, OP_MON_SUB, S_MON, C_NEVER, OP_NONE, S_IDLE,
                    OP_MON_DONE, S_OUT};
      S_OUT:  w = '{C_NEVER, OP_NONE, S_IDLE, C_NEVER, OP_NONE, S_IDLE,
                    OP_NONE, S_IDLE};
      default: w = '{C_NEVER, OP_NONE, S_IDLE, C_NEVER, OP_NONE, S_IDLE,
                     OP_NONE, S_IDLE};
    endcase
    return w;
  endfunction

  // gregorian leap rule, with the year's remainder by 100 kept alongside
  function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                   input logic [M100_W-1:0] m100);
    return (y[1:0] == 2'd0) && ((m100 != '0) || (y[3:0] == 4'd0));
  endfunction

  // length of a month, zero for a month code outside the year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    logic [DAY_W-1:0] n;
    idx = m - MONTH_W'(1);
    n = '0;
    if ((m != '0) && (m <= MONTH_MAX)) begin
      n = MONTH_LEN[idx];
      if ((m == FEBRUARY) && leap) begin
        n = n + DAY_W'(1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/date_minus_days_core.sv =====
// channel   | ports                                   | transfer
// ----------+-----------------------------------------+------------------------------
// command   | in_year in_month in_day days_back       | start high while busy low
// result    | out_year out_month out_day status       | done high, one cycle
//
// steps: load, year mod 100 by repeated subtraction of 100, date check, day of year of the
//   start date month by month, the year walk back, the month walk into the result year,
//   then the result transfer; an invalid date ends after the check, an underflow during
//   the year walk
// reset: rst (synchronous) returns the sequencer to idle; no clearing pass
// stalls: none on the result side; a new command is taken once busy falls
`default_nettype none

module date_minus_days_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [dmd_pkg::YEAR_W-1:0]     in_year,
  input  wire logic [dmd_pkg::MONTH_W-1:0]    in_month,
  input  wire logic [dmd_pkg::DAY_W-1:0]      in_day,
  input  wire logic [dmd_pkg::DAYS_BITS-1:0]  days_back,
  output logic                                done,
  output logic [dmd_pkg::YEAR_W-1:0]          out_year,
  output logic [dmd_pkg::MONTH_W-1:0]         out_month,
  output logic [dmd_pkg::DAY_W-1:0]           out_day,
  output logic [1:0]                          status
);

  dmd_pkg::step_t pc, pc_next;
  dmd_pkg::ucode_t uw;
  dmd_pkg::op_t op;

  logic [dmd_pkg::YEAR_W-1:0]    yr, yr_next;
  logic [dmd_pkg::YEAR_W-1:0]    cnt, cnt_next;
  logic [dmd_pkg::M100_W-1:0]    m100, m100_next;
  logic [dmd_pkg::MONTH_W-1:0]   mo, mo_next;
  logic [dmd_pkg::MONTH_W-1:0]   mi, mi_next;
  logic [dmd_pkg::DAY_W-1:0]     dy, dy_next;
  logic [dmd_pkg::DOY_W-1:0]     doy, doy_next;
  logic [dmd_pkg::DAYS_BITS-1:0] rem, rem_next;

  logic [dmd_pkg::YEAR_W-1:0]  out_year_next;
  logic [dmd_pkg::MONTH_W-1:0] out_month_next;
  logic [dmd_pkg::DAY_W-1:0]   out_day_next;
  logic [1:0]                  status_next;

  logic                          leap_cur, leap_prev;
  logic [dmd_pkg::YEAR_W-1:0]    yr_dec;
  logic [dmd_pkg::M100_W-1:0]    m100_dec;
  logic [dmd_pkg::DAY_W-1:0]     start_len, iter_len;
  logic [dmd_pkg::WIDE_W-1:0]    rem_x, doy_x;
  logic                          hit_a, hit_b;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dmd_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    yr        <= yr_next;
    cnt       <= cnt_next;
    m100      <= m100_next;
    mo        <= mo_next;
    mi        <= mi_next;
    dy        <= dy_next;
    doy       <= doy_next;
    rem       <= rem_next;
    out_year  <= out_year_next;
    out_month <= out_month_next;
    out_day   <= out_day_next;
    status    <= status_next;
  end

  // calendar helpers on the current and the previous year
  always_comb begin
    yr_dec    = yr - dmd_pkg::YEAR_W'(1);
    m100_dec  = (m100 == '0) ? dmd_pkg::M100_W'(99) : m100 - dmd_pkg::M100_W'(1);
    leap_cur  = dmd_pkg::is_leap(yr, m100);
    leap_prev = dmd_pkg::is_leap(yr_dec, m100_dec);
    start_len = dmd_pkg::month_days(mo, leap_cur);
    iter_len  = dmd_pkg::month_days(mi, leap_cur);
    rem_x     = dmd_pkg::WIDE_W'(rem);
    doy_x     = dmd_pkg::WIDE_W'(doy);
  end

  // condition select
  function automatic logic cond_true(input dmd_pkg::cond_t c, input logic go,
                                     input logic ge100, input logic bad,
                                     input logic mi_lt, input logic fit,
                                     input logic first, input logic more);
    logic r;
    r = 1'b0;
    unique case (c)
      dmd_pkg::C_NEVER:    r = 1'b0;
      dmd_pkg::C_START:    r = go;
      dmd_pkg::C_GE100:    r = ge100;
      dmd_pkg::C_BAD:      r = bad;
      dmd_pkg::C_MI_LT:    r = mi_lt;
      dmd_pkg::C_FIT:      r = fit;
      dmd_pkg::C_FIRST:    r = first;
      dmd_pkg::C_MON_MORE: r = more;
      default:             r = 1'b0;
    endcase
    return r;
  endfunction

  // control word fetch and branch
  always_comb begin
    logic go, ge100, bad, mi_lt, fit, first, more;
    go    = start;
    ge100 = cnt >= dmd_pkg::CENTURY;
    bad   = (yr == '0) || (yr > dmd_pkg::YEAR_MAX) || (mo == '0) ||
            (mo > dmd_pkg::MONTH_MAX) || (dy == '0) || (dy > start_len);
    mi_lt = mi < mo;
    fit   = rem_x <= doy_x;
    first = yr == dmd_pkg::YEAR_W'(1);
    more  = (mi != dmd_pkg::MONTH_MAX) && (doy >= dmd_pkg::DOY_W'(iter_len));
    uw    = dmd_pkg::ucode(pc);
    hit_a = cond_true(uw.cond_a, go, ge100, bad, mi_lt, fit, first, more);
    hit_b = cond_true(uw.cond_b, go, ge100, bad, mi_lt, fit, first, more);
    if (hit_a) begin
      op      = uw.op_a;
      pc_next = uw.tgt_a;
    end else if (hit_b) begin
      op      = uw.op_b;
      pc_next = uw.tgt_b;
    end else begin
      op      = uw.op_c;
      pc_next = uw.tgt_c;
    end
    busy = pc != dmd_pkg::S_IDLE;
    done = pc == dmd_pkg::S_OUT;
  end

  // datapath operations
  always_comb begin
    yr_next        = yr;
    cnt_next       = cnt;
    m100_next      = m100;
    mo_next        = mo;
    mi_next        = mi;
    dy_next        = dy;
    doy_next       = doy;
    rem_next       = rem;
    out_year_next  = out_year;
    out_month_next = out_month;
    out_day_next   = out_day;
    status_next    = status;
    case (op) inside
      dmd_pkg::OP_LOAD: begin
        yr_next  = in_year;
        cnt_next = in_year;
        mo_next  = in_month;
        dy_next  = in_day;
        rem_next = days_back;
      end
      dmd_pkg::OP_MOD_SUB: begin
        cnt_next = cnt - dmd_pkg::CENTURY;
      end
      dmd_pkg::OP_MOD_DONE: begin
        m100_next = cnt[dmd_pkg::M100_W-1:0];
      end
      dmd_pkg::OP_BAD, dmd_pkg::OP_UFL: begin
        out_year_next  = '0;
        out_month_next = '0;
        out_day_next   = '0;
        status_next    = (op == dmd_pkg::OP_BAD) ? dmd_pkg::ST_INVALID
                                                 : dmd_pkg::ST_UNDERFLOW;
      end
      dmd_pkg::OP_DOY_INIT: begin
        doy_next = '0;
        mi_next  = dmd_pkg::MONTH_W'(1);
      end
      dmd_pkg::OP_DOY_ADD: begin
        doy_next = doy + dmd_pkg::DOY_W'(iter_len);
        mi_next  = mi + dmd_pkg::MONTH_W'(1);
      end
      dmd_pkg::OP_DOY_DAY: begin
        doy_next = doy + dmd_pkg::DOY_W'(dy) - dmd_pkg::DOY_W'(1);
      end
      dmd_pkg::OP_FIT: begin
        doy_next = dmd_pkg::DOY_W'(doy_x - rem_x);
        mi_next  = dmd_pkg::MONTH_W'(1);
      end
      dmd_pkg::OP_YEAR_BACK: begin
        rem_next  = dmd_pkg::DAYS_BITS'(rem_x - (doy_x + dmd_pkg::WIDE_W'(1)));
        yr_next   = yr_dec;
        m100_next = m100_dec;
        doy_next  = leap_prev ? dmd_pkg::DOY_W'(365) : dmd_pkg::DOY_W'(364);
      end
      dmd_pkg::OP_MON_SUB: begin
        doy_next = doy - dmd_pkg::DOY_W'(iter_len);
        mi_next  = mi + dmd_pkg::MONTH_W'(1);
      end
      dmd_pkg::OP_MON_DONE: begin
        out_year_next  = yr;
        out_month_next = mi;
        out_day_next   = dmd_pkg::DAY_W'(doy + dmd_pkg::DOY_W'(1));
        status_next    = dmd_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/dmd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module dmd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [dmd_pkg::YEAR_W-1:0]  out_year,
  input wire logic [dmd_pkg::MONTH_W-1:0] out_month,
  input wire logic [dmd_pkg::DAY_W-1:0]   out_day,
  input wire logic [1:0]                  status
);

  // a taken command keeps the block busy
  `ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)
  // the result cycle ends the command
  `ASSERT_NEXT(a_done_free, clk, rst, done, !busy && !done)
  // error results carry an all-zero date
  `ASSERT_SAME(a_err_zero, clk, rst, done && (status != dmd_pkg::ST_OK),
               (out_year == '0) && (out_month == '0) && (out_day == '0))
  // good results carry a real date
  `ASSERT_SAME(a_ok_date, clk, rst, done && (status == dmd_pkg::ST_OK),
               (out_year != '0) && (out_month != '0) && (out_day != '0) &&
               (out_month <= dmd_pkg::MONTH_MAX))

endmodule

bind date_minus_days_core dmd_checker u_dmd_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .out_year(out_year),
  .out_month(out_month),
  .out_day(out_day),
  .status(status)
);

`default_nettype wire

// ===== tb/date_minus_days_core_tb.sv =====
`default_nettype none

module date_minus_days_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transfer on either side before the run is called hung
  localparam int IDLE_LIMIT = 40000;
  // settle time after the last result, enough for one more stray strobe
  localparam int TAIL_CYCLES = 64;
  // day counts of the gregorian cycles used to split a day number
  localparam int unsigned DAYS_PER_400Y = 146097;
  localparam int unsigned DAYS_PER_100Y = 36524;
  localparam int unsigned DAYS_PER_4Y = 1461;
  localparam int unsigned DAYS_PER_YEAR = 365;

  typedef struct {
    logic [dmd_pkg::YEAR_W-1:0]  year;
    logic [dmd_pkg::MONTH_W-1:0] month;
    logic [dmd_pkg::DAY_W-1:0]   day;
    logic [1:0]                  status;
  } date_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [dmd_pkg::YEAR_W-1:0]    in_year = '0;
  logic [dmd_pkg::MONTH_W-1:0]   in_month = '0;
  logic [dmd_pkg::DAY_W-1:0]     in_day = '0;
  logic [dmd_pkg::DAYS_BITS-1:0] days_back = '0;
  logic                          busy;
  logic                          done;
  logic [dmd_pkg::YEAR_W-1:0]    out_year;
  logic [dmd_pkg::MONTH_W-1:0]   out_month;
  logic [dmd_pkg::DAY_W-1:0]     out_day;
  logic [1:0]                    status;

  date_result_t pending_dates[$];
  int unsigned  err_count = 0;
  int unsigned  sent_count = 0;
  int unsigned  checked_count = 0;
  int unsigned  ok_count = 0;
  int unsigned  invalid_count = 0;
  int unsigned  underflow_count = 0;
  int unsigned  idle_cycles = 0;
  bit           no_gaps = 1'b0;

  date_minus_days_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .days_back (days_back),
    .done      (done),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .status    (status)
  );

  always #1 clk = ~clk;

  // gregorian calendar helpers for the predictor
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m) inside
      4, 6, 9, 11: n = 30;
      2: n = leap_year(y) ? 29 : 28;
      default: n = 31;
    endcase
    return n;
  endfunction

  // days elapsed since 0001-01-01 for a valid date
  function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned i = 1; i < m; i++) begin
      n += month_length(y, i);
    end
    return n + d - 1;
  endfunction

  // date a given number of days before the start date, with status
  function automatic date_result_t predict_earlier_date(
      input logic [dmd_pkg::YEAR_W-1:0] y,
      input logic [dmd_pkg::MONTH_W-1:0] m,
      input logic [dmd_pkg::DAY_W-1:0] d,
      input logic [dmd_pkg::DAYS_BITS-1:0] back);
    date_result_t r;
    int unsigned left;
    int unsigned n400;
    int unsigned n100;
    int unsigned n4;
    int unsigned n1;
    int unsigned yr;
    int unsigned mo;
    r.year = '0;
    r.month = '0;
    r.day = '0;
    r.status = dmd_pkg::ST_OK;
    if (y < 1 || y > dmd_pkg::YEAR_MAX || m < 1 || m > dmd_pkg::MONTH_MAX || d < 1 ||
        d > month_length(y, m)) begin
      r.status = dmd_pkg::ST_INVALID;
      return r;
    end
    left = day_number(y, m, d);
    if (back > left) begin
      r.status = dmd_pkg::ST_UNDERFLOW;
      return r;
    end
    left = left - back;
    // split into 400, 100, 4 and 1 year blocks; the last block of each may be one day longer
    n400 = left / DAYS_PER_400Y;
    left = left % DAYS_PER_400Y;
    n100 = left / DAYS_PER_100Y;
    if (n100 > 3) n100 = 3;
    left = left - n100 * DAYS_PER_100Y;
    n4 = left / DAYS_PER_4Y;
    left = left % DAYS_PER_4Y;
    n1 = left / DAYS_PER_YEAR;
    if (n1 > 3) n1 = 3;
    left = left - n1 * DAYS_PER_YEAR;
    yr = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
    mo = 1;
    while (mo < 12 && left >= month_length(yr, mo)) begin
      left -= month_length(yr, mo);
      mo++;
    end
    r.year = yr[dmd_pkg::YEAR_W-1:0];
    r.month = mo[dmd_pkg::MONTH_W-1:0];
    r.day = dmd_pkg::DAY_W'(left + 1);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             checked_count);
    err_count++;
  endtask

  // one command transfer; start stays high when the next command follows at once
  task automatic send_date(input logic [dmd_pkg::YEAR_W-1:0] y,
                           input logic [dmd_pkg::MONTH_W-1:0] m,
                           input logic [dmd_pkg::DAY_W-1:0] d,
                           input logic [dmd_pkg::DAYS_BITS-1:0] back);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_year <= y;
    in_month <= m;
    in_day <= d;
    days_back <= back;
    do @(posedge clk); while (busy);
    pending_dates.push_back(predict_earlier_date(y, m, d, back));
    sent_count++;
  endtask

  // hold off new commands until every outstanding result is back
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // calendar edges, every error class and the zero count
  task automatic test_edge_dates();
    no_gaps = 1'b1;
    send_date(1, 1, 1, 0);
    send_date(1, 1, 1, 1);
    send_date(9999, 12, 31, 0);
    send_date(9999, 12, 31, 3652058);
    send_date(9999, 12, 31, 3652059);
    send_date(9999, 12, 31, 4194303);
    send_date(2000, 3, 1, 1);
    send_date(2000, 2, 29, 0);
    send_date(2100, 3, 1, 1);
    no_gaps = 1'b0;
    send_date(1900, 2, 29, 0);
    send_date(2024, 2, 29, 366);
    send_date(2001, 1, 1, 366);
    send_date(2001, 1, 1, 365);
    send_date(2000, 1, 1, 365);
    send_date(0, 6, 15, 10);
    send_date(10000, 1, 1, 0);
    send_date(16383, 15, 31, 4194303);
    send_date(2023, 0, 10, 5);
    send_date(2023, 13, 10, 5);
    send_date(2023, 15, 10, 5);
    send_date(2023, 5, 0, 5);
    send_date(2023, 4, 31, 5);
    send_date(2023, 1, 31, 31);
    send_date(8191, 12, 31, 2796202);
  endtask

  // valid dates with counts spread from a few days to the whole calendar
  task automatic test_calendar_walk(input int unsigned count);
    logic [dmd_pkg::YEAR_W-1:0]    y;
    logic [dmd_pkg::MONTH_W-1:0]   m;
    logic [dmd_pkg::DAY_W-1:0]     d;
    int unsigned                   first_day;
    logic [dmd_pkg::DAYS_BITS-1:0] back;
    for (int unsigned i = 0; i < count; i++) begin
      // stretches with and without gaps, chosen at random every 25 dates
      if (i % 25 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i == count / 2) wait_for_results();
      y = ($urandom_range(0, 4) == 0)
          ? dmd_pkg::YEAR_W'($urandom_range(0, 99) * 100 + 1)
          : dmd_pkg::YEAR_W'($urandom_range(1, 9999));
      m = dmd_pkg::MONTH_W'($urandom_range(1, 12));
      d = ($urandom_range(0, 3) == 0)
          ? dmd_pkg::DAY_W'(month_length(y, m))
          : dmd_pkg::DAY_W'($urandom_range(1, month_length(y, m)));
      first_day = day_number(y, m, d);
      case ($urandom_range(0, 9)) inside
        0, 1, 2: back = dmd_pkg::DAYS_BITS'($urandom_range(0, 400));
        3, 4, 5: back = dmd_pkg::DAYS_BITS'($urandom_range(0, 40000));
        6, 7, 8: back = dmd_pkg::DAYS_BITS'($urandom_range(0, first_day));
        default: back = dmd_pkg::DAYS_BITS'(first_day + $urandom_range(0, 3));
      endcase
      send_date(y, m, d, back);
    end
  endtask

  // raw field values, mostly invalid dates and oversized counts
  task automatic test_raw_fields(input int unsigned count);
    no_gaps = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      send_date(dmd_pkg::YEAR_W'($urandom_range(0, 16383)),
                dmd_pkg::MONTH_W'($urandom_range(0, 15)),
                dmd_pkg::DAY_W'($urandom_range(0, 31)),
                dmd_pkg::DAYS_BITS'($urandom));
    end
  endtask

  // result check against the oldest prediction
  always @(posedge clk) begin
    date_result_t want;
    if (!rst && done) begin
      checked_count++;
      case (status)
        dmd_pkg::ST_OK: ok_count++;
        dmd_pkg::ST_INVALID: invalid_count++;
        default: underflow_count++;
      endcase
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_year !== want.year) report_mismatch("out_year", out_year, want.year);
        if (out_month !== want.month) report_mismatch("out_month", out_month, want.month);
        if (out_day !== want.day) report_mismatch("out_day", out_day, want.day);
        if (status !== want.status) report_mismatch("status", status, want.status);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_dates();
    test_calendar_walk(150);
    test_raw_fields(30);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d dates sent, %0d results checked", sent_count, checked_count);
    $display("results: %0d ok, %0d invalid date, %0d before year one", ok_count,
             invalid_count, underflow_count);
    if (err_count == 0 && pending_dates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
